[rtl/lpht_pkg.sv]
// lpht_pkg: request/response payload types, function and slot mode codes,
// and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package lpht_pkg;

  // fixed field widths of the request and response channels
  localparam int FUNC_W  = 2;
  localparam int KEY_W   = 32;
  localparam int HASH_W  = 32;
  localparam int VALUE_W = 64;

  // defaults for the top level parameters
  localparam int SLOTS_DEF      = 256;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 64;

  // hash reduction for table sizes that are not a power of two
  localparam int HASH_BITS_PER_STEP = 8;
  localparam int HASH_STEPS         = HASH_W / HASH_BITS_PER_STEP;
  localparam int HSTEP_W            = $clog2(HASH_STEPS);

  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SET    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;

  localparam logic [1:0] MODE_EMPTY = 2'd0;
  localparam logic [1:0] MODE_FULL  = 2'd1;
  localparam logic [1:0] MODE_TOMB  = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [KEY_W-1:0]   key;
    logic [HASH_W-1:0]  key_hash;
    logic [VALUE_W-1:0] value_in;
  } lpht_req_t;

  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] value_out;
    logic               status;
  } lpht_rsp_t;

  typedef struct packed {
    logic accept;
    logic clear;
    logic hash_step;
    logic probe;
    logic finish;
  } lpht_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic used_zero;
    logic load_full;
    logic hash_last;
    logic probe_end;
  } lpht_sts_t;

endpackage

`default_nettype wire

[rtl/lpht_ctrl.sv]
// lpht_ctrl: sequencing state machine of the hash table (clear, hash, probe,
// finish) and the response valid register.
// Depends on lpht_pkg.
`default_nettype none

module lpht_ctrl #(
  parameter int SLOTS = lpht_pkg::SLOTS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [lpht_pkg::FUNC_W-1:0]   in_func,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output lpht_pkg::lpht_cmd_t                cmd,
  input  wire lpht_pkg::lpht_sts_t           sts
);

  localparam bit POW2 = ((SLOTS & (SLOTS - 1)) == 0);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_FETCH,
    ST_PROBE,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   skip;
  logic   out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // requests that need no probe: empty table, load limit, unused code
  always_comb begin
    skip = 1'b0;
    case (in_func)
      lpht_pkg::FUNC_LOOKUP: skip = sts.used_zero;
      lpht_pkg::FUNC_DELETE: skip = sts.used_zero;
      lpht_pkg::FUNC_SET:    skip = sts.load_full;
      default:               skip = 1'b1;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (skip) begin
            state_nxt = ST_FINISH;
          end else if (POW2) begin
            state_nxt = ST_FETCH;
          end else begin
            state_nxt = ST_HASH;
          end
        end
      end
      ST_HASH: begin
        cmd.hash_step = 1'b1;
        if (sts.hash_last) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_nxt = ST_PROBE;
      end
      ST_PROBE: begin
        cmd.probe = 1'b1;
        if (sts.probe_end) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/lpht_dp.sv]
// lpht_dp: slot memories, probe index and bookkeeping, hash reduction,
// occupied count and the response register.
// Depends on lpht_pkg; driven by lpht_ctrl commands.
`default_nettype none

module lpht_dp #(
  parameter int SLOTS      = lpht_pkg::SLOTS_DEF,
  parameter int KEY_BITS   = lpht_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lpht_pkg::VALUE_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire lpht_pkg::lpht_req_t  in_data,
  input  wire lpht_pkg::lpht_cmd_t  cmd,
  output lpht_pkg::lpht_sts_t       sts,
  output lpht_pkg::lpht_rsp_t       out_data
);

  localparam int  IDX_W = $clog2(SLOTS);
  localparam int  CNT_W = $clog2(SLOTS + 1);
  localparam int  CHK_W = CNT_W + 3;
  localparam int  LIMIT = 3 * SLOTS;
  localparam int  VW    = lpht_pkg::VALUE_W;
  localparam int  HW    = lpht_pkg::HASH_W;
  localparam int  BPS   = lpht_pkg::HASH_BITS_PER_STEP;
  localparam int  SW    = lpht_pkg::HSTEP_W;
  localparam bit  POW2  = ((SLOTS & (SLOTS - 1)) == 0);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

  // slot memories
  logic [KEY_BITS-1:0]   key_mem   [SLOTS];
  logic [VALUE_BITS-1:0] value_mem [SLOTS];
  logic [1:0]            mode_mem  [SLOTS];

  logic [KEY_BITS-1:0]   rd_key_r;
  logic [VALUE_BITS-1:0] rd_val_r;
  logic [1:0]            rd_mode_r;

  // request registers
  logic [lpht_pkg::FUNC_W-1:0] func_r, func_nxt;
  logic [KEY_BITS-1:0]         key_r, key_nxt;
  logic [VALUE_BITS-1:0]       val_r, val_nxt;
  logic [HW-1:0]               hsh_r, hsh_nxt;
  logic [SW-1:0]               hstep_r, hstep_nxt;

  // probe state
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [IDX_W-1:0]      cnt_r, cnt_nxt;
  logic                  tomb_v_r, tomb_v_nxt;
  logic [IDX_W-1:0]      tomb_idx_r, tomb_idx_nxt;
  logic [IDX_W-1:0]      tgt_idx_r, tgt_idx_nxt;
  logic [1:0]            tgt_mode_r, tgt_mode_nxt;
  logic                  none_r, none_nxt;
  logic [VALUE_BITS-1:0] hit_val_r, hit_val_nxt;
  logic [CNT_W-1:0]      used_r, used_nxt;
  lpht_pkg::lpht_rsp_t   rsp_r, rsp_nxt;

  logic [IDX_W-1:0] idx_inc;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] hash_rem;
  logic [CHK_W-1:0] used_p1;
  logic             is_empty, is_match, is_tomb, is_last, probe_end;
  logic             is_set, is_look, is_del, found_full;
  logic             wr_kv, wr_mode;
  logic [IDX_W-1:0] wr_addr;
  logic [1:0]       wr_mode_val;

  assign idx_inc   = (idx_r == IDX_LAST) ? '0 : idx_r + 1'b1;
  assign is_empty  = (rd_mode_r == lpht_pkg::MODE_EMPTY);
  assign is_match  = (rd_mode_r == lpht_pkg::MODE_FULL) && (rd_key_r == key_r);
  assign is_tomb   = !is_empty && (rd_mode_r != lpht_pkg::MODE_FULL);
  assign is_last   = (cnt_r == IDX_LAST);
  assign probe_end = is_empty || is_match || is_last;
  assign rd_addr   = (cmd.probe && !probe_end) ? idx_inc : idx_r;

  assign used_p1 = CHK_W'(used_r) + CHK_W'(1);

  assign sts.clear_last = (idx_r == IDX_LAST);
  assign sts.used_zero  = (used_r == '0);
  assign sts.load_full  = (used_p1 << 2) > CHK_W'(LIMIT);
  assign sts.hash_last  = (hstep_r == SW'(lpht_pkg::HASH_STEPS - 1));
  assign sts.probe_end  = probe_end;

  assign is_set     = (func_r == lpht_pkg::FUNC_SET);
  assign is_look    = (func_r == lpht_pkg::FUNC_LOOKUP);
  assign is_del     = (func_r == lpht_pkg::FUNC_DELETE);
  assign found_full = !none_r && (tgt_mode_r == lpht_pkg::MODE_FULL);

  // remainder of the hash, one byte of the hash per step
  always_comb begin
    logic [IDX_W:0] t;
    hash_rem = idx_r;
    for (int i = 0; i < BPS; i++) begin
      t = {hash_rem, hsh_r[HW-1-i]};
      if (t >= (IDX_W + 1)'(SLOTS)) begin
        t = t - (IDX_W + 1)'(SLOTS);
      end
      hash_rem = t[IDX_W-1:0];
    end
  end

  always_comb begin
    func_nxt     = func_r;
    key_nxt      = key_r;
    val_nxt      = val_r;
    hsh_nxt      = hsh_r;
    hstep_nxt    = hstep_r;
    idx_nxt      = idx_r;
    cnt_nxt      = cnt_r;
    tomb_v_nxt   = tomb_v_r;
    tomb_idx_nxt = tomb_idx_r;
    tgt_idx_nxt  = tgt_idx_r;
    tgt_mode_nxt = tgt_mode_r;
    none_nxt     = none_r;
    hit_val_nxt  = hit_val_r;
    used_nxt     = used_r;
    rsp_nxt      = rsp_r;

    if (cmd.clear) begin
      idx_nxt = idx_inc;
    end

    if (cmd.accept) begin
      func_nxt   = in_data.func;
      key_nxt    = KEY_BITS'(in_data.key);
      val_nxt    = VALUE_BITS'(in_data.value_in);
      hsh_nxt    = in_data.key_hash;
      hstep_nxt  = '0;
      cnt_nxt    = '0;
      tomb_v_nxt = 1'b0;
      none_nxt   = 1'b1;
      if (POW2) begin
        idx_nxt = in_data.key_hash[IDX_W-1:0];
      end else begin
        idx_nxt = '0;
      end
    end

    if (cmd.hash_step) begin
      idx_nxt   = hash_rem;
      hsh_nxt   = hsh_r << BPS;
      hstep_nxt = hstep_r + 1'b1;
    end

    if (cmd.probe) begin
      if (is_match) begin
        tgt_idx_nxt  = idx_r;
        tgt_mode_nxt = lpht_pkg::MODE_FULL;
        none_nxt     = 1'b0;
        hit_val_nxt  = rd_val_r;
      end else if (is_empty) begin
        none_nxt = 1'b0;
        if (tomb_v_r) begin
          tgt_idx_nxt  = tomb_idx_r;
          tgt_mode_nxt = lpht_pkg::MODE_TOMB;
        end else begin
          tgt_idx_nxt  = idx_r;
          tgt_mode_nxt = lpht_pkg::MODE_EMPTY;
        end
      end else if (is_last) begin
        // whole table visited: fall back to the first tombstone, if any
        if (tomb_v_r) begin
          none_nxt     = 1'b0;
          tgt_idx_nxt  = tomb_idx_r;
          tgt_mode_nxt = lpht_pkg::MODE_TOMB;
        end else if (is_tomb) begin
          none_nxt     = 1'b0;
          tgt_idx_nxt  = idx_r;
          tgt_mode_nxt = lpht_pkg::MODE_TOMB;
        end
      end else begin
        if (is_tomb && !tomb_v_r) begin
          tomb_v_nxt   = 1'b1;
          tomb_idx_nxt = idx_r;
        end
        idx_nxt = idx_inc;
        cnt_nxt = cnt_r + 1'b1;
      end
    end

    if (cmd.finish) begin
      rsp_nxt.hit       = 1'b0;
      rsp_nxt.value_out = '0;
      rsp_nxt.status    = 1'b0;
      if (is_look) begin
        rsp_nxt.hit = found_full;
        if (found_full) begin
          rsp_nxt.value_out = VW'(hit_val_r);
        end
      end else if (is_set) begin
        rsp_nxt.status = none_r;
        rsp_nxt.hit    = !none_r && (tgt_mode_r != lpht_pkg::MODE_FULL);
        if (!none_r && (tgt_mode_r == lpht_pkg::MODE_EMPTY)) begin
          used_nxt = used_r + 1'b1;
        end
      end else if (is_del) begin
        rsp_nxt.hit = found_full;
      end
    end
  end

  // single write port, shared by the clearing pass and request completion
  always_comb begin
    wr_kv       = cmd.finish && is_set && !none_r;
    wr_mode     = cmd.clear || wr_kv || (cmd.finish && is_del && found_full);
    wr_addr     = cmd.clear ? idx_r : tgt_idx_r;
    wr_mode_val = lpht_pkg::MODE_EMPTY;
    if (!cmd.clear) begin
      wr_mode_val = is_set ? lpht_pkg::MODE_FULL : lpht_pkg::MODE_TOMB;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_kv) begin
      key_mem[wr_addr]   <= key_r;
      value_mem[wr_addr] <= val_r;
    end
    if (wr_mode) begin
      mode_mem[wr_addr] <= wr_mode_val;
    end
    rd_key_r  <= key_mem[rd_addr];
    rd_val_r  <= value_mem[rd_addr];
    rd_mode_r <= mode_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      used_r <= '0;
    end else begin
      idx_r  <= idx_nxt;
      used_r <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    key_r      <= key_nxt;
    val_r      <= val_nxt;
    hsh_r      <= hsh_nxt;
    hstep_r    <= hstep_nxt;
    cnt_r      <= cnt_nxt;
    tomb_v_r   <= tomb_v_nxt;
    tomb_idx_r <= tomb_idx_nxt;
    tgt_idx_r  <= tgt_idx_nxt;
    tgt_mode_r <= tgt_mode_nxt;
    none_r     <= none_nxt;
    hit_val_r  <= hit_val_nxt;
    rsp_r      <= rsp_nxt;
  end

  assign out_data = rsp_r;

endmodule

`default_nettype wire

[rtl/linear_probe_hash_table_top.sv]
// Open-addressing hash table with linear probing and tombstones.
// Request channel in_valid/in_ready/in_data carries func (lookup, set,
// delete), key, key_hash and value_in; one response per request leaves on
// out_valid/out_ready/out_data with hit, value_out and status.
// Probing starts at key_hash mod SLOTS and reads one slot per cycle from
// slot memories with a single write port. A request passes through
// accept, memory fetch, one probe step per probed slot and completion.
// Table sizes that are not a power of two add hash reduction steps
// before the fetch (8 hash bits per cycle). Requests that need no probe
// (empty table, load limit, unused code) go from accept straight to
// completion. A set is refused with status 1 when the load would
// pass three quarters of SLOTS.
// After reset the slot mode memory is cleared one slot per cycle, so
// in_ready stays low until the clear is done. A response waits in the
// output register while out_ready is low; the next request is accepted
// and probed meanwhile, and completes once the output register is free.
// Depends on lpht_pkg, lpht_ctrl, lpht_dp.
`default_nettype none

module linear_probe_hash_table_top #(
  parameter int SLOTS      = lpht_pkg::SLOTS_DEF,
  parameter int KEY_BITS   = lpht_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lpht_pkg::VALUE_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire lpht_pkg::lpht_req_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output lpht_pkg::lpht_rsp_t       out_data
);

  lpht_pkg::lpht_cmd_t cmd;
  lpht_pkg::lpht_sts_t sts;

  lpht_ctrl #(
    .SLOTS(SLOTS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_func  (in_data.func),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  lpht_dp #(
    .SLOTS     (SLOTS),
    .KEY_BITS  (KEY_BITS),
    .VALUE_BITS(VALUE_BITS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .cmd     (cmd),
    .sts     (sts),
    .out_data(out_data)
  );

endmodule

`default_nettype wire
